/* rtl/core/windowed_least_squares_line_fit_top_defines.svh */
// Assertion macros for the windowed least-squares line fit.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef WINDOWED_LEAST_SQUARES_LINE_FIT_TOP_DEFINES_SVH
`define WINDOWED_LEAST_SQUARES_LINE_FIT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define WLSF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define WLSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/wlsf_pkg.sv */
// Shared types and constants for the windowed least-squares line fit.
// No dependencies; used by wlsf_muldiv and the top level.
package wlsf_pkg;

	localparam int unsigned MAX_POINTS_DEF = 1024;
	localparam int unsigned MIN_POINTS_DEF = 3;

	localparam int XY_W       = 16;   // Q8.8 sample width
	localparam int OUT_W      = 32;   // Q16.16 result width
	localparam int PTS_W      = 11;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 80;
	localparam int M_TUSER_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// numerator pre-scaling ahead of the divisions
	localparam int SLOPE_SHIFT = 16;
	localparam int ICPT_SHIFT  = 8;

	// output packing
	localparam int SLOPE_LSB = 0;
	localparam int ICPT_LSB  = 32;
	localparam int PTS_LSB   = 64;
	localparam int USER_OK   = 0;
	localparam int USER_OVF  = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd2;

	// window axis codes; any other code means no filtering
	localparam logic [1:0] AXIS_NONE = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_X    = 2'd2;

	localparam logic [1:0]             AXIS_RST = AXIS_Y;
	localparam logic signed [XY_W-1:0] LOW_RST  = 16'sd1792;   // 7.0
	localparam logic signed [XY_W-1:0] HIGH_RST = 16'sd6656;   // 26.0

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIT,
		ST_DEN1,
		ST_DEN2,
		ST_M1,
		ST_M2,
		ST_DIVM,
		ST_B1,
		ST_B2,
		ST_DIVB,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		op_t  op;
		logic clear;   // multiply: start from a zero accumulator
		logic neg;     // multiply: subtract product; divide: negative numerator
	} unit_cmd_t;

endpackage

/* rtl/core/wlsf_muldiv.sv */
// Shared bit-serial unit: shift-add multiply-accumulate and restoring divide
// with a saturated 32-bit quotient. Depends on wlsf_pkg.
module wlsf_muldiv #(
	parameter int AW = 42,
	parameter int MW = 26
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  wlsf_pkg::unit_cmd_t                         cmd,
	input  logic [AW-1:0]                               a_mag,
	input  logic [MW-1:0]                               b_mag,
	input  logic [AW+MW+2+wlsf_pkg::SLOPE_SHIFT-1:0]    num_mag,
	input  logic [AW+MW:0]                              den,
	output logic                                        busy,
	output logic [AW+MW+1:0]                            acc,
	output logic [wlsf_pkg::OUT_W-1:0]                  quo
);
	import wlsf_pkg::*;

	localparam int ACW   = AW + MW + 2;
	localparam int NW    = ACW + SLOPE_SHIFT;
	localparam int CNT_W = $clog2(NW + 1);

	localparam logic [OUT_W:0]   POS_LIM = {2'b00, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W:0]   NEG_LIM = {2'b01, {(OUT_W-1){1'b0}}};

	logic             busy_q;
	op_t              mode_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [ACW-1:0]   acc_q;
	logic [ACW-1:0]   opb_q;
	logic [MW-1:0]    b_q;
	logic [NW-1:0]    num_q;
	logic [OUT_W:0]   quo_q;
	logic             big_q;

	logic [ACW-1:0]   add_a;
	logic [ACW-1:0]   add_b;
	logic             add_sub;
	logic [ACW:0]     add_sum;
	logic             over;
	logic [OUT_W-1:0] quo_mag;

	// single adder serves both operations
	always_comb begin
		if (mode_q == OP_DIV) begin
			add_a   = {acc_q[ACW-2:0], num_q[NW-1]};
			add_b   = opb_q;
			add_sub = 1'b1;
		end else begin
			add_a   = acc_q;
			add_b   = opb_q;
			add_sub = neg_q;
		end
		add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (ACW+1)'(add_sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= OP_NONE;
			cnt_q  <= '0;
		end else if (cmd.op == OP_MUL) begin
			busy_q <= 1'b1;
			mode_q <= OP_MUL;
			cnt_q  <= CNT_W'(MW);
		end else if (cmd.op == OP_DIV) begin
			busy_q <= 1'b1;
			mode_q <= OP_DIV;
			cnt_q  <= CNT_W'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_MUL) begin
			neg_q <= cmd.neg;
			opb_q <= ACW'(a_mag);
			b_q   <= b_mag;
			if (cmd.clear)
				acc_q <= '0;
		end else if (cmd.op == OP_DIV) begin
			neg_q <= cmd.neg;
			opb_q <= ACW'(den);
			num_q <= num_mag;
			acc_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			case (mode_q)
				OP_MUL: begin
					if (b_q[0])
						acc_q <= add_sum[ACW-1:0];
					opb_q <= {opb_q[ACW-2:0], 1'b0};
					b_q   <= {1'b0, b_q[MW-1:1]};
				end
				OP_DIV: begin
					// carry out set means partial remainder >= divisor
					acc_q <= add_sum[ACW] ? add_sum[ACW-1:0] : add_a;
					quo_q <= {quo_q[OUT_W-1:0], add_sum[ACW]};
					big_q <= big_q | quo_q[OUT_W];
					num_q <= {num_q[NW-2:0], 1'b0};
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (neg_q)
			over = big_q || (quo_q > NEG_LIM);
		else
			over = big_q || (quo_q > POS_LIM);
		if (over)
			quo_mag = neg_q ? NEG_LIM[OUT_W-1:0] : POS_LIM[OUT_W-1:0];
		else
			quo_mag = quo_q[OUT_W-1:0];
	end

	assign quo  = neg_q ? (~quo_mag + 1'b1) : quo_mag;
	assign busy = busy_q;
	assign acc  = acc_q;

endmodule

/* rtl/core/windowed_least_squares_line_fit_top.sv */
// Windowed least-squares line fit: point filter, running sums and fit sequencer.
// Depends on wlsf_pkg, wlsf_muldiv and the assertion macro header.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready   | tdata x, y; tlast ends the point set
//  m_      | out | m_tvalid / m_tready   | tdata slope, intercept, count; tuser flags
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// A point without tlast is filtered, multiplied (16x16 products) and summed in one go.
// A last point also starts the fit through the shared bit-serial unit; s_tready stays low
// until the result is loaded into the output register, which waits while it is full.
// Too few points or a zero denominator ends the fit early.
// Reset clears sums, count and configuration to their initial values at once.
`include "windowed_least_squares_line_fit_top_defines.svh"

module windowed_least_squares_line_fit_top #(
	parameter int unsigned MAX_POINTS = wlsf_pkg::MAX_POINTS_DEF,
	parameter int unsigned MIN_POINTS = wlsf_pkg::MIN_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wlsf_pkg::S_TDATA_W-1:0]    s_tdata,    // x_value[15:0], y_value[31:16]
	input  logic                              s_tlast,    // last_point
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wlsf_pkg::M_TDATA_W-1:0]    m_tdata,    // slope_out[31:0], intercept_out[63:32],
	                                                      // points_used[74:64], zero[79:75]
	output logic [wlsf_pkg::M_TUSER_W-1:0]    m_tuser,    // fit_ok[0], overflow_flag[1]
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wlsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wlsf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import wlsf_pkg::*;

	localparam int LG   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int SXW  = XY_W + LG;
	localparam int SXXW = 2*XY_W - 1 + LG;
	localparam int SXYW = 2*XY_W + LG;
	localparam int AW   = SXYW;
	localparam int MW   = SXW;
	localparam int ACW  = AW + MW + 2;
	localparam int DW   = ACW - 1;
	localparam int NW   = ACW + SLOPE_SHIFT;

	// configuration
	logic [1:0]             axis_q;
	logic signed [XY_W-1:0] low_q;
	logic signed [XY_W-1:0] high_q;

	// running sums
	logic [CW-1:0]          count_q;
	logic signed [SXW-1:0]  sum_x_q;
	logic signed [SXW-1:0]  sum_y_q;
	logic [SXXW-1:0]        sum_xx_q;
	logic signed [SXYW-1:0] sum_xy_q;
	logic                   dropped_q;

	state_t                 state_q, state_d;
	logic [DW-1:0]          den_q;
	logic [OUT_W-1:0]       slope_q;
	logic [OUT_W-1:0]       icpt_q;
	logic                   ok_q;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;
	logic [M_TUSER_W-1:0]   m_tuser_q;

	logic                     in_xfer;
	logic signed [XY_W-1:0]   x_in;
	logic signed [XY_W-1:0]   y_in;
	logic                     pass;
	logic signed [2*XY_W-1:0] xx;
	logic signed [2*XY_W-1:0] xy;

	logic          sx_neg, sy_neg, sxy_neg;
	logic [MW-1:0] sx_mag, sy_mag, n_ext;
	logic [AW-1:0] sxy_mag, sxx_ext;

	unit_cmd_t        cmd;
	logic [AW-1:0]    a_mag;
	logic [MW-1:0]    b_mag;
	logic [NW-1:0]    num_mag;
	logic             u_busy;
	logic [ACW-1:0]   u_acc;
	logic [OUT_W-1:0] u_quo;
	logic             acc_neg;
	logic [ACW-1:0]   acc_mag;

	logic fit_start, load_den, cap_slope, cap_icpt, load_out;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign x_in      = s_tdata[XY_W-1:0];
	assign y_in      = s_tdata[2*XY_W-1:XY_W];
	assign xx        = x_in * x_in;
	assign xy        = x_in * y_in;

	always_comb begin
		case (axis_q)
			AXIS_Y:  pass = (y_in > low_q) && (y_in < high_q);
			AXIS_X:  pass = (x_in > low_q) && (x_in < high_q);
			default: pass = 1'b1;
		endcase
	end

	// operand magnitudes for the shared unit
	assign sx_neg  = sum_x_q[SXW-1];
	assign sy_neg  = sum_y_q[SXW-1];
	assign sxy_neg = sum_xy_q[SXYW-1];
	assign sx_mag  = sx_neg ? MW'(-sum_x_q) : MW'(sum_x_q);
	assign sy_mag  = sy_neg ? MW'(-sum_y_q) : MW'(sum_y_q);
	assign sxy_mag = sxy_neg ? AW'(-sum_xy_q) : AW'(sum_xy_q);
	assign sxx_ext = AW'(sum_xx_q);
	assign n_ext   = MW'(count_q);
	assign acc_neg = u_acc[ACW-1];
	assign acc_mag = acc_neg ? (~u_acc + 1'b1) : u_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= AXIS_RST;
			low_q  <= LOW_RST;
			high_q <= HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_AXIS: axis_q <= cfg_data[1:0];
				REG_LOW:  low_q  <= cfg_data;
				REG_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			sum_xx_q  <= '0;
			sum_xy_q  <= '0;
			dropped_q <= 1'b0;
		end else if (load_out) begin
			count_q   <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			sum_xx_q  <= '0;
			sum_xy_q  <= '0;
			dropped_q <= 1'b0;
		end else if (in_xfer && pass) begin
			if (32'(count_q) < MAX_POINTS) begin
				count_q  <= count_q + 1'b1;
				sum_x_q  <= sum_x_q + SXW'(x_in);
				sum_y_q  <= sum_y_q + SXW'(y_in);
				sum_xx_q <= sum_xx_q + SXXW'(xx[2*XY_W-2:0]);
				sum_xy_q <= sum_xy_q + SXYW'(xy);
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// sequencer: ST_DEN1 to ST_DIVB wait for the unit, then issue an operation or capture a result
	always_comb begin
		state_d   = state_q;
		cmd       = '{op: OP_NONE, clear: 1'b0, neg: 1'b0};
		a_mag     = '0;
		b_mag     = '0;
		num_mag   = '0;
		fit_start = 1'b0;
		load_den  = 1'b0;
		cap_slope = 1'b0;
		cap_icpt  = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && s_tlast)
					state_d = ST_FIT;
			end
			ST_FIT: begin
				fit_start = 1'b1;
				if (32'(count_q) >= MIN_POINTS) begin
					cmd     = '{op: OP_MUL, clear: 1'b1, neg: 1'b0};
					a_mag   = sxx_ext;
					b_mag   = n_ext;
					state_d = ST_DEN1;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DEN1: begin
				if (!u_busy) begin
					cmd     = '{op: OP_MUL, clear: 1'b0, neg: 1'b1};
					a_mag   = AW'(sx_mag);
					b_mag   = sx_mag;
					state_d = ST_DEN2;
				end
			end
			ST_DEN2: begin
				if (!u_busy) begin
					load_den = 1'b1;
					if (u_acc == '0) begin
						state_d = ST_OUT;
					end else begin
						cmd     = '{op: OP_MUL, clear: 1'b1, neg: sxy_neg};
						a_mag   = sxy_mag;
						b_mag   = n_ext;
						state_d = ST_M1;
					end
				end
			end
			ST_M1: begin
				if (!u_busy) begin
					cmd     = '{op: OP_MUL, clear: 1'b0, neg: ~(sx_neg ^ sy_neg)};
					a_mag   = AW'(sy_mag);
					b_mag   = sx_mag;
					state_d = ST_M2;
				end
			end
			ST_M2: begin
				if (!u_busy) begin
					cmd     = '{op: OP_DIV, clear: 1'b0, neg: acc_neg};
					num_mag = {acc_mag, {SLOPE_SHIFT{1'b0}}};
					state_d = ST_DIVM;
				end
			end
			ST_DIVM: begin
				if (!u_busy) begin
					cap_slope = 1'b1;
					cmd       = '{op: OP_MUL, clear: 1'b1, neg: sy_neg};
					a_mag     = sxx_ext;
					b_mag     = sy_mag;
					state_d   = ST_B1;
				end
			end
			ST_B1: begin
				if (!u_busy) begin
					cmd     = '{op: OP_MUL, clear: 1'b0, neg: ~(sx_neg ^ sxy_neg)};
					a_mag   = sxy_mag;
					b_mag   = sx_mag;
					state_d = ST_B2;
				end
			end
			ST_B2: begin
				if (!u_busy) begin
					cmd     = '{op: OP_DIV, clear: 1'b0, neg: acc_neg};
					num_mag = {{(SLOPE_SHIFT-ICPT_SHIFT){1'b0}}, acc_mag, {ICPT_SHIFT{1'b0}}};
					state_d = ST_DIVB;
				end
			end
			ST_DIVB: begin
				if (!u_busy) begin
					cap_icpt = 1'b1;
					state_d  = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fit_start) begin
			slope_q <= '0;
			icpt_q  <= '0;
			ok_q    <= 1'b0;
		end
		if (load_den)
			den_q <= u_acc[DW-1:0];
		if (cap_slope)
			slope_q <= u_quo;
		if (cap_icpt) begin
			icpt_q <= u_quo;
			ok_q   <= 1'b1;
		end
		if (load_out) begin
			m_tdata_q <= {{(M_TDATA_W-PTS_LSB-PTS_W){1'b0}}, PTS_W'(count_q), icpt_q, slope_q};
			m_tuser_q <= {dropped_q, ok_q};
		end
	end

	wlsf_muldiv #(
		.AW (AW),
		.MW (MW)
	) u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.a_mag   (a_mag),
		.b_mag   (b_mag),
		.num_mag (num_mag),
		.den     (den_q),
		.busy    (u_busy),
		.acc     (u_acc),
		.quo     (u_quo)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`WLSF_ASSERT_SAME(a_busy_blocks_input, u_busy, !s_tready, "input ready while the fit unit runs")
	`WLSF_ASSERT_SAME(a_failed_fit_zero, m_tvalid && !m_tuser[USER_OK], m_tdata[ICPT_LSB+OUT_W-1:0] == '0, "failed fit with nonzero coefficients")
	`WLSF_ASSERT_NEXT(a_result_clears_sums, load_out, count_q == '0 && !dropped_q && sum_xy_q == '0, "sums not cleared after result")

endmodule
